>>> rtl/core/hcd_pkg.sv
`timescale 1ns / 1ps

package hcd_pkg;

    localparam int QueueDepth = 4;

    localparam logic [4:0] MaxDigits = 5'd16;
    localparam logic [7:0] CharCr    = 8'h0D;
    localparam logic [7:0] CharLf    = 8'h0A;
    localparam logic [7:0] CharSemi  = 8'h3B;

    typedef enum logic [2:0] {
        PH_DIGITS,
        PH_EXT,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_END,
        PH_ERR
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_batch;
    } in_item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       body_done;
        logic       error;
        logic       batch_end;
    } out_item_t;

    // classified byte handed from the front to the back through the queue
    typedef struct packed {
        logic       is_hex;
        logic [3:0] hex_value;
        logic       is_semi;
        logic       is_cr;
        logic       is_lf;
        logic [7:0] data_byte;
        logic       last_of_batch;
    } byte_class_t;

endpackage

>>> rtl/core/hcd_front.sv
`timescale 1ns / 1ps

module hcd_front
(
    input  logic                in_valid,
    output logic                in_ready,
    input  hcd_pkg::in_item_t   in_data,
    input  logic                queue_full,
    output logic                push,
    output hcd_pkg::byte_class_t push_class
);

    logic [7:0] b;

    assign b        = in_data.data_byte;
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_class               = '0;
        push_class.data_byte     = b;
        push_class.last_of_batch = in_data.last_of_batch;
        push_class.is_semi       = (b == hcd_pkg::CharSemi);
        push_class.is_cr         = (b == hcd_pkg::CharCr);
        push_class.is_lf         = (b == hcd_pkg::CharLf);
        if (b inside {[8'h30:8'h39]})
        begin
            push_class.is_hex    = 1'b1;
            push_class.hex_value = b[3:0];
        end
        else if (b inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            // letters a..f in either case: low nibble 1..6 maps to 10..15
            push_class.is_hex    = 1'b1;
            push_class.hex_value = b[3:0] + 4'd9;
        end
    end

endmodule

>>> rtl/core/hcd_queue.sv
`timescale 1ns / 1ps

module hcd_queue
#(
    parameter int DEPTH = hcd_pkg::QueueDepth
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hcd_pkg::byte_class_t push_class,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output hcd_pkg::byte_class_t head_class
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hcd_pkg::byte_class_t entries [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_class = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_class;
        end
    end

endmodule

>>> rtl/core/hcd_back.sv
`timescale 1ns / 1ps

module hcd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  hcd_pkg::byte_class_t head_class,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hcd_pkg::out_item_t   out_data
);

    hcd_pkg::phase_t    phase_reg, phase_next;
    logic [63:0]        remaining_reg, remaining_next;
    logic [4:0]         digits_reg, digits_next;
    logic               out_valid_reg, out_valid_next;
    hcd_pkg::out_item_t out_data_reg, out_data_next;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        digits_next    = digits_reg;
        if (pop)
        begin
            case (phase_reg)
                hcd_pkg::PH_DIGITS:
                begin
                    if (head_class.is_hex)
                    begin
                        if (digits_reg >= hcd_pkg::MaxDigits)
                        begin
                            phase_next = hcd_pkg::PH_ERR;
                        end
                        else
                        begin
                            remaining_next = {remaining_reg[59:0], head_class.hex_value};
                            digits_next    = digits_reg + 5'd1;
                        end
                    end
                    else if (head_class.is_semi)
                    begin
                        phase_next = hcd_pkg::PH_EXT;
                    end
                    else if (head_class.is_cr)
                    begin
                        phase_next = hcd_pkg::PH_SIZE_LF;
                    end
                    else
                    begin
                        phase_next = hcd_pkg::PH_ERR;
                    end
                end
                hcd_pkg::PH_EXT:
                begin
                    if (head_class.is_cr)
                    begin
                        phase_next = hcd_pkg::PH_SIZE_LF;
                    end
                end
                hcd_pkg::PH_SIZE_LF:
                begin
                    if (!head_class.is_lf || digits_reg == '0)
                    begin
                        phase_next = hcd_pkg::PH_ERR;
                    end
                    else if (remaining_reg == '0)
                    begin
                        phase_next = hcd_pkg::PH_END;
                    end
                    else
                    begin
                        phase_next = hcd_pkg::PH_DATA;
                    end
                end
                hcd_pkg::PH_DATA:
                begin
                    remaining_next = remaining_reg - 64'd1;
                    if (remaining_reg == 64'd1)
                    begin
                        phase_next = hcd_pkg::PH_DATA_CR;
                    end
                end
                hcd_pkg::PH_DATA_CR:
                begin
                    phase_next = head_class.is_cr ? hcd_pkg::PH_DATA_LF : hcd_pkg::PH_ERR;
                end
                hcd_pkg::PH_DATA_LF:
                begin
                    if (head_class.is_lf)
                    begin
                        phase_next     = hcd_pkg::PH_DIGITS;
                        remaining_next = '0;
                        digits_next    = '0;
                    end
                    else
                    begin
                        phase_next = hcd_pkg::PH_ERR;
                    end
                end
                hcd_pkg::PH_END:
                begin
                    phase_next = hcd_pkg::PH_END;
                end
                default:
                begin
                    phase_next = hcd_pkg::PH_ERR;
                end
            endcase
        end
    end

    // result item: end and error flags reflect the phase after this byte, payload_valid the phase before it
    always_comb
    begin
        out_data_next               = '0;
        out_data_next.payload_valid = (phase_reg == hcd_pkg::PH_DATA);
        out_data_next.payload_byte  = (phase_reg == hcd_pkg::PH_DATA) ?
                                      head_class.data_byte : 8'd0;
        out_data_next.body_done     = (phase_next == hcd_pkg::PH_END);
        out_data_next.error         = (phase_next == hcd_pkg::PH_ERR);
        out_data_next.batch_end     = head_class.last_of_batch;

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hcd_pkg::PH_DIGITS;
            remaining_reg <= '0;
            digits_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            digits_reg    <= digits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

>>> rtl/core/http_chunked_decoder.sv
`timescale 1ns / 1ps

// channel   signals                         direction  item
// in        in_valid, in_ready, in_data     input      one raw byte of the chunked body
// out       out_valid, out_ready, out_data  output     one result per byte
//
// one byte accepted per cycle while the queue is not full; its result reaches the output
// through the queue (written at the accepting edge) and then the fsm output register
// the 64-bit size decrement and zero test of the decode fsm set the cycle time
// reset clears the queue, the fsm (size digits phase) and the output valid
// an output stall fills the queue; in_ready drops only while the queue is full

module http_chunked_decoder
#(
    parameter int QUEUE_DEPTH = hcd_pkg::QueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hcd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hcd_pkg::out_item_t out_data
);

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 head_valid;
    hcd_pkg::byte_class_t push_class;
    hcd_pkg::byte_class_t head_class;

    hcd_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_class (push_class)
    );

    hcd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_class (push_class),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_class (head_class)
    );

    hcd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_class (head_class),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

>>> rtl/core/hcd_checker.sv
`timescale 1ns / 1ps

module hcd_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  hcd_pkg::out_item_t out_data
);

    logic seen_err_reg;
    logic seen_end_reg;
    logic out_take;

    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_err_reg <= 1'b0;
            seen_end_reg <= 1'b0;
        end
        else
        begin
            if (out_take && out_data.error)
            begin
                seen_err_reg <= 1'b1;
            end
            if (out_take && out_data.body_done)
            begin
                seen_end_reg <= 1'b1;
            end
        end
    end

    // error is sticky across items
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_err_reg |-> out_data.error)
        else $error("error flag dropped after being reported");

    // end of stream is sticky and never meets a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_end_reg |-> out_data.body_done && !out_data.payload_valid)
        else $error("stream end dropped or payload after end");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.payload_valid |-> !out_data.error && !out_data.body_done)
        else $error("payload byte together with end or error");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
        else $error("payload byte not zero without payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

endmodule

bind http_chunked_decoder hcd_checker u_checker (.*);

>>> test/tb_http_chunked_decoder.sv
`timescale 1ns / 1ps

module tb_http_chunked_decoder;

    typedef enum int {
        END_ZERO_CHUNK,
        END_BAD_CHAR,
        END_SPACE,
        END_TOO_MANY_DIGITS,
        END_EMPTY_SIZE,
        END_EMPTY_WITH_EXT,
        END_NO_SIZE_LF,
        END_NO_DATA_CR,
        END_NO_DATA_LF,
        END_HUGE_SIZE
    } stream_close_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    hcd_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    hcd_pkg::out_item_t out_data;

    // decoder shadow state
    hcd_pkg::phase_t dec_phase;
    logic [63:0]     dec_remaining;
    logic [4:0]      dec_digits;

    hcd_pkg::out_item_t pending_results[$];
    int                 error_count;
    int                 bytes_sent;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    http_chunked_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_lookup(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return {1'b1, b[3:0]};
        if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            return {1'b1, b[3:0] + 4'd9};
        return 5'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        if ($urandom_range(0, 1) == 0)
            return 8'h61 + 8'(n - 4'd10);
        return 8'h41 + 8'(n - 4'd10);
    endfunction

    function automatic int digits_needed(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 16 && (v >> (4 * n)) != 0)
            n++;
        return n;
    endfunction

    task automatic decode_byte(input hcd_pkg::in_item_t item, output hcd_pkg::out_item_t res);
        logic [7:0] b;
        logic [4:0] hx;
        b = item.data_byte;
        hx = hex_lookup(b);
        res = '0;
        case (dec_phase)
            hcd_pkg::PH_DIGITS:
            begin
                if (hx[4])
                begin
                    if (dec_digits >= hcd_pkg::MaxDigits)
                        dec_phase = hcd_pkg::PH_ERR;
                    else
                    begin
                        dec_remaining = {dec_remaining[59:0], hx[3:0]};
                        dec_digits = dec_digits + 5'd1;
                    end
                end
                else if (b == hcd_pkg::CharSemi)
                    dec_phase = hcd_pkg::PH_EXT;
                else if (b == hcd_pkg::CharCr)
                    dec_phase = hcd_pkg::PH_SIZE_LF;
                else
                    dec_phase = hcd_pkg::PH_ERR;
            end
            hcd_pkg::PH_EXT:
            begin
                if (b == hcd_pkg::CharCr)
                    dec_phase = hcd_pkg::PH_SIZE_LF;
            end
            hcd_pkg::PH_SIZE_LF:
            begin
                if (b != hcd_pkg::CharLf || dec_digits == 5'd0)
                    dec_phase = hcd_pkg::PH_ERR;
                else if (dec_remaining == 64'd0)
                    dec_phase = hcd_pkg::PH_END;
                else
                    dec_phase = hcd_pkg::PH_DATA;
            end
            hcd_pkg::PH_DATA:
            begin
                res.payload_valid = 1'b1;
                res.payload_byte = b;
                dec_remaining = dec_remaining - 64'd1;
                if (dec_remaining == 64'd0)
                    dec_phase = hcd_pkg::PH_DATA_CR;
            end
            hcd_pkg::PH_DATA_CR:
            begin
                dec_phase = (b == hcd_pkg::CharCr) ? hcd_pkg::PH_DATA_LF : hcd_pkg::PH_ERR;
            end
            hcd_pkg::PH_DATA_LF:
            begin
                if (b == hcd_pkg::CharLf)
                begin
                    dec_phase = hcd_pkg::PH_DIGITS;
                    dec_remaining = 64'd0;
                    dec_digits = 5'd0;
                end
                else
                    dec_phase = hcd_pkg::PH_ERR;
            end
            hcd_pkg::PH_END:
            begin
            end
            default:
            begin
                dec_phase = hcd_pkg::PH_ERR;
            end
        endcase
        res.body_done = (dec_phase == hcd_pkg::PH_END);
        res.error = (dec_phase == hcd_pkg::PH_ERR);
        res.batch_end = item.last_of_batch;
    endtask

    // predict on every accepted byte
    always @(posedge clk)
    begin : accept_monitor
        hcd_pkg::out_item_t predicted;
        if (rst_n && in_valid && in_ready)
        begin
            decode_byte(in_data, predicted);
            pending_results.push_back(predicted);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        hcd_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %0h", $time, out_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("payload_valid", 8'(want.payload_valid),
                            8'(out_data.payload_valid));
                check_field("payload_byte", want.payload_byte, out_data.payload_byte);
                check_field("body_done", 8'(want.body_done), 8'(out_data.body_done));
                check_field("error", 8'(want.error), 8'(out_data.error));
                check_field("batch_end", 8'(want.batch_end), 8'(out_data.batch_end));
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        hcd_pkg::in_item_t item;
        item.data_byte = b;
        item.last_of_batch = ($urandom_range(0, 7) == 0);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_size_line(input logic [63:0] value, input int ndigits,
                                  input bit with_ext);
        logic [7:0] b;
        for (int i = ndigits - 1; i >= 0; i--)
            send_byte(hex_char(value[4 * i +: 4]));
        if (with_ext)
        begin
            send_byte(hcd_pkg::CharSemi);
            repeat ($urandom_range(0, 5))
            begin
                b = 8'($urandom_range(0, 255));
                // lf is legal inside an extension, so bias toward it
                if (b == hcd_pkg::CharCr)
                    b = hcd_pkg::CharLf;
                send_byte(b);
            end
        end
        send_byte(hcd_pkg::CharCr);
        send_byte(hcd_pkg::CharLf);
    endtask

    task automatic send_payload(input int count);
        repeat (count)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_chunk();
        int len;
        int nd;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 255) : $urandom_range(1, 16);
        nd = digits_needed(64'(len)) + $urandom_range(0, 2);
        send_size_line(64'(len), nd, ($urandom_range(0, 3) == 0));
        send_payload(len);
        send_byte(hcd_pkg::CharCr);
        send_byte(hcd_pkg::CharLf);
    endtask

    task automatic test_max_digits();
        // sixteen digits, all but the last leading zeros
        send_size_line(64'd1, 16, 1'b0);
        send_byte(8'hFF);
        send_byte(hcd_pkg::CharCr);
        send_byte(hcd_pkg::CharLf);
    endtask

    task automatic test_extension();
        send_byte(8'h31);
        send_byte(hcd_pkg::CharSemi);
        send_byte(hcd_pkg::CharLf);
        send_byte(hcd_pkg::CharCr);
        send_byte(hcd_pkg::CharLf);
        send_byte(8'h00);
        send_byte(hcd_pkg::CharCr);
        send_byte(hcd_pkg::CharLf);
    endtask

    task automatic test_random_chunks(input int count, input int send_pct, input int recv_pct);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_chunk();
    endtask

    // end and error are both sticky, so only one way of closing the stream per run
    task automatic test_stream_close();
        stream_close_t kind;
        logic [7:0]    b;
        logic [4:0]    hx;
        logic [63:0]   v;
        kind = stream_close_t'($urandom_range(0, 9));
        case (kind)
            END_ZERO_CHUNK:
                send_size_line(64'd0, $urandom_range(1, 16), 1'($urandom_range(0, 1)));
            END_BAD_CHAR:
            begin
                repeat ($urandom_range(0, 3))
                    send_byte(hex_char(4'($urandom_range(0, 15))));
                do
                begin
                    b = 8'($urandom_range(0, 255));
                    hx = hex_lookup(b);
                end
                while (hx[4] || b == hcd_pkg::CharSemi || b == hcd_pkg::CharCr);
                send_byte(b);
            end
            END_SPACE:
            begin
                send_byte(8'h31);
                send_byte(8'h20);
            end
            END_TOO_MANY_DIGITS:
                repeat (17)
                    send_byte(hex_char(4'($urandom_range(0, 15))));
            END_EMPTY_SIZE:
            begin
                send_byte(hcd_pkg::CharCr);
                send_byte(hcd_pkg::CharLf);
            end
            END_EMPTY_WITH_EXT:
                send_size_line(64'd0, 0, 1'b1);
            END_NO_SIZE_LF:
            begin
                send_byte(hex_char(4'($urandom_range(1, 15))));
                send_byte(hcd_pkg::CharCr);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == hcd_pkg::CharLf);
                send_byte(b);
            end
            END_NO_DATA_CR:
            begin
                send_size_line(64'd2, 1, 1'b0);
                send_payload(2);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == hcd_pkg::CharCr);
                send_byte(b);
            end
            END_NO_DATA_LF:
            begin
                send_size_line(64'd2, 1, 1'b0);
                send_payload(2);
                send_byte(hcd_pkg::CharCr);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == hcd_pkg::CharLf);
                send_byte(b);
            end
            default:
            begin
                v = {1'b1, 31'($urandom), 32'($urandom)};
                send_size_line(v, 16, 1'b0);
                send_payload(30);
            end
        endcase
        // trailing bytes after the stream is closed (more payload for the huge size case)
        send_payload(24);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        dec_phase = hcd_pkg::PH_DIGITS;
        dec_remaining = 64'd0;
        dec_digits = 5'd0;
        error_count = 0;
        bytes_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_max_digits();
        test_extension();
        test_random_chunks(500, 26, 45);
        test_random_chunks(500, 45, 26);
        test_random_chunks(500, 0, 0);
        test_stream_close();
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
